// ===== rtl/air_sample_window_classifier_core_macros.svh =====
// Assertion macros for the classifier RTL.
// Expects clk and rst_n in the scope of use.
`ifndef AIR_SAMPLE_WINDOW_CLASSIFIER_CORE_MACROS_SVH
`define AIR_SAMPLE_WINDOW_CLASSIFIER_CORE_MACROS_SVH

// same-cycle implication
`define ASWC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aswc assertion failed");

// next-cycle implication
`define ASWC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aswc assertion failed");

`endif

// ===== rtl/aswc_pkg.sv =====
// Types, constants and helpers for the air sample window classifier.
// No dependencies.
package aswc_pkg;

    localparam int FRAC_BITS = 8;
    localparam int VOC_W     = 16;
    localparam int BASE_W    = VOC_W + FRAC_BITS;
    localparam int DIFF_W    = BASE_W + 2;
    localparam int SUM_W     = BASE_W + 3;
    localparam int DIV_SHIFT = SUM_W + 3;
    localparam int DIV_M_W   = DIV_SHIFT - 1;
    localparam int PROD_W    = SUM_W + DIV_M_W;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    // ceil(2^DIV_SHIFT / 5): exact floor division by 5 for any SUM_W-bit sum
    localparam logic [DIV_M_W-1:0] DIV_M =
        DIV_M_W'(((64'd1 << DIV_SHIFT) + 64'd4) / 64'd5);

    localparam logic [BASE_W-1:0] BASE_RESET  = BASE_W'(64'd500 << FRAC_BITS);
    localparam logic [BASE_W-1:0] ADIFF_QUIET = BASE_W'(64'd10 << FRAC_BITS);
    localparam logic [BASE_W-1:0] ADIFF_SPIKE = BASE_W'(64'd5 << FRAC_BITS);

    localparam logic [31:0] INTERVAL_RESET = 32'd300000;
    localparam logic [23:0] LOW_GAS_RESET  = 24'd10000;
    localparam logic [23:0] SUSP_GAS_RESET = 24'd25000;
    localparam logic [23:0] CLEAN_GAS_RESET = 24'd45000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INTERVAL  = 2'd0,
        REG_LOW_GAS   = 2'd1,
        REG_SUSP_GAS  = 2'd2,
        REG_CLEAN_GAS = 2'd3
    } reg_idx_t;

    typedef enum logic [4:0] {
        CAT_LETHAL_OPIOID   = 5'd0,
        CAT_COCKTAIL        = 5'd1,
        CAT_NEUROTOXIN      = 5'd2,
        CAT_HEAVY_METAL     = 5'd3,
        CAT_ORGANOPHOSPHATE = 5'd4,
        CAT_GASEOUS         = 5'd5,
        CAT_OPIOID          = 5'd6,
        CAT_SCOPOLAMINE     = 5'd7,
        CAT_KNOCKOUT        = 5'd8,
        CAT_STEALTH_CHEM    = 5'd9,
        CAT_IAQ_ANOMALY     = 5'd10,
        CAT_LPG_SPIKE       = 5'd11,
        CAT_LPG_ONLY        = 5'd12,
        CAT_STEALTH_CONTAM  = 5'd13,
        CAT_MASKED          = 5'd14,
        CAT_CLEAN           = 5'd15,
        CAT_UNKNOWN         = 5'd16
    } cat_t;

    typedef struct packed {
        logic [31:0]        time_ms;
        logic [15:0]        voc_milli;
        logic [12:0]        iaq_tenths;
        logic [13:0]        pm25_tenths;
        logic [9:0]         humidity_tenths;
        logic signed [10:0] temp_tenths;
        logic [23:0]        gas_ohms;
        logic               spike_in;
    } sample_t;

    typedef struct packed {
        cat_t        category;
        logic        is_threat;
        logic        is_spike;
        logic        spike_negative;
        logic [15:0] spike_magnitude;
    } result_t;

    typedef struct packed {
        logic [31:0] baseline_interval_ms;
        logic [23:0] low_gas_limit;
        logic [23:0] suspicious_gas_limit;
        logic [23:0] clean_gas_limit;
    } cfg_t;

    function automatic logic win(input logic [23:0] v, input logic [23:0] lo,
                                 input logic [23:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic logic win_s(input logic signed [10:0] v,
                                   input logic signed [10:0] lo,
                                   input logic signed [10:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

endpackage

// ===== rtl/air_sample_window_classifier_core.sv =====
// Air sample window classifier: takes one timestamped air sample per cycle
// while not stalled and returns one result item (category, threat, spike info)
// per sample. Throughput is one item per clock when nothing stalls; an input
// register precedes the result register, with the baseline EMA multiply and
// the window compares between them. A stalled result holds the input register,
// which then stalls the sample side. Config writes take effect next cycle.
// Depends on aswc_pkg, aswc_baseline, aswc_classify and the macros header.
`include "air_sample_window_classifier_core_macros.svh"

module air_sample_window_classifier_core (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,

    input  logic                sample_valid,
    output logic                sample_stall,
    input  logic [31:0]         time_ms,
    input  logic [15:0]         voc_milli,
    input  logic [12:0]         iaq_tenths,
    input  logic [13:0]         pm25_tenths,
    input  logic [9:0]          humidity_tenths,
    input  logic signed [10:0]  temp_tenths,
    input  logic [23:0]         gas_ohms,
    input  logic                spike_in,

    output logic                result_valid,
    input  logic                result_stall,
    output logic [4:0]          category,
    output logic                is_threat,
    output logic                is_spike,
    output logic                spike_negative,
    output logic [15:0]         spike_magnitude
);

    aswc_pkg::cfg_t              cfg_reg;
    aswc_pkg::cfg_t              cfg_next;
    aswc_pkg::sample_t           s1_reg;
    aswc_pkg::sample_t           s1_next;
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    aswc_pkg::result_t           res_reg;
    aswc_pkg::result_t           res_next;
    logic                        res_valid_reg;
    logic                        res_valid_next;
    logic                        accept;
    logic                        advance;
    logic [aswc_pkg::BASE_W-1:0] baseline;
    aswc_pkg::result_t           res_comb;

    assign advance      = s1_valid_reg && (!res_valid_reg || !result_stall);
    assign sample_stall = s1_valid_reg && !advance;
    assign accept       = sample_valid && !sample_stall;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (aswc_pkg::reg_idx_t'(cfg_index))
                aswc_pkg::REG_INTERVAL:  cfg_next.baseline_interval_ms = cfg_data;
                aswc_pkg::REG_LOW_GAS:   cfg_next.low_gas_limit        = cfg_data[23:0];
                aswc_pkg::REG_SUSP_GAS:  cfg_next.suspicious_gas_limit = cfg_data[23:0];
                aswc_pkg::REG_CLEAN_GAS: cfg_next.clean_gas_limit      = cfg_data[23:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        s1_next = s1_reg;
        if (accept)
        begin
            s1_next.time_ms         = time_ms;
            s1_next.voc_milli       = voc_milli;
            s1_next.iaq_tenths      = iaq_tenths;
            s1_next.pm25_tenths     = pm25_tenths;
            s1_next.humidity_tenths = humidity_tenths;
            s1_next.temp_tenths     = temp_tenths;
            s1_next.gas_ohms        = gas_ohms;
            s1_next.spike_in        = spike_in;
        end
        s1_valid_next = accept || (s1_valid_reg && !advance);
    end

    aswc_baseline u_baseline (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .time_ms   (s1_reg.time_ms),
        .voc_milli (s1_reg.voc_milli),
        .interval  (cfg_reg.baseline_interval_ms),
        .baseline  (baseline)
    );

    aswc_classify u_classify (
        .sample   (s1_reg),
        .baseline (baseline),
        .cfg      (cfg_reg),
        .result   (res_comb)
    );

    always_comb
    begin
        res_next       = advance ? res_comb : res_reg;
        res_valid_next = advance || (res_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.baseline_interval_ms <= aswc_pkg::INTERVAL_RESET;
            cfg_reg.low_gas_limit        <= aswc_pkg::LOW_GAS_RESET;
            cfg_reg.suspicious_gas_limit <= aswc_pkg::SUSP_GAS_RESET;
            cfg_reg.clean_gas_limit      <= aswc_pkg::CLEAN_GAS_RESET;
            s1_valid_reg                 <= 1'b0;
            res_valid_reg                <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg  <= s1_next;
        res_reg <= res_next;
    end

    assign result_valid    = res_valid_reg;
    assign category        = res_reg.category;
    assign is_threat       = res_reg.is_threat;
    assign is_spike        = res_reg.is_spike;
    assign spike_negative  = res_reg.spike_negative;
    assign spike_magnitude = res_reg.spike_magnitude;

    `ASWC_ASSERT_NEXT(a_s1_holds, s1_valid_reg && !advance, s1_valid_reg)
    `ASWC_ASSERT_NOW(a_spike_fields_zero,
        res_valid_reg && (res_reg.category != aswc_pkg::CAT_LPG_SPIKE),
        !res_reg.spike_negative && (res_reg.spike_magnitude == 16'd0))
    `ASWC_ASSERT_NOW(a_window_threat,
        res_valid_reg && (res_reg.category <= aswc_pkg::CAT_LPG_SPIKE), res_reg.is_threat)
    `ASWC_ASSERT_NOW(a_lpg_only_safe,
        res_valid_reg && (res_reg.category == aswc_pkg::CAT_LPG_ONLY), !res_reg.is_threat)

endmodule

// ===== rtl/aswc_baseline.sv =====
// VOC baseline state: interval check and 0.8/0.2 EMA by reciprocal multiply.
// Depends on aswc_pkg.
module aswc_baseline (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic [31:0]                     time_ms,
    input  logic [15:0]                     voc_milli,
    input  logic [31:0]                     interval,
    output logic [aswc_pkg::BASE_W-1:0]     baseline
);

    logic [aswc_pkg::BASE_W-1:0] base_reg;
    logic [aswc_pkg::BASE_W-1:0] base_next;
    logic [31:0]                 last_reg;
    logic [31:0]                 last_next;
    logic [31:0]                 elapsed;
    logic                        update;
    logic [aswc_pkg::SUM_W-1:0]  sum;
    logic [aswc_pkg::PROD_W-1:0] prod;
    logic [aswc_pkg::BASE_W-1:0] quot;

    assign elapsed = time_ms - last_reg;
    assign update  = elapsed > interval;

    // floor((4*b + (voc << F)) / 5)
    assign sum  = aswc_pkg::SUM_W'({base_reg, 2'b00})
                + aswc_pkg::SUM_W'(aswc_pkg::BASE_W'(voc_milli) << aswc_pkg::FRAC_BITS);
    assign prod = aswc_pkg::PROD_W'(sum) * aswc_pkg::PROD_W'(aswc_pkg::DIV_M);
    assign quot = prod[aswc_pkg::DIV_SHIFT +: aswc_pkg::BASE_W];

    assign baseline = update ? quot : base_reg;

    always_comb
    begin
        base_next = base_reg;
        last_next = last_reg;
        if (advance)
        begin
            base_next = baseline;
            if (update)
            begin
                last_next = time_ms;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= aswc_pkg::BASE_RESET;
            last_reg <= 32'd0;
        end
        else
        begin
            base_reg <= base_next;
            last_reg <= last_next;
        end
    end

endmodule

// ===== rtl/aswc_classify.sv =====
// Window tests in priority order, baseline anomaly checks and gas fallbacks.
// Pure combinational; depends on aswc_pkg.
module aswc_classify (
    input  aswc_pkg::sample_t               sample,
    input  logic [aswc_pkg::BASE_W-1:0]     baseline,
    input  aswc_pkg::cfg_t                  cfg,
    output aswc_pkg::result_t               result
);

    logic [23:0]                  voc;
    logic [23:0]                  iaq;
    logic [23:0]                  pm;
    logic [23:0]                  hum;
    logic [23:0]                  gas;
    logic signed [10:0]           temp;
    logic [aswc_pkg::BASE_W-1:0]  vs;
    logic [aswc_pkg::DIFF_W-1:0]  diff;
    logic [aswc_pkg::DIFF_W-1:0]  diff_abs;
    logic [aswc_pkg::BASE_W-1:0]  adiff;
    logic                         diff_neg;
    logic                         low;
    logic                         susp;
    logic                         lpg_gas;
    aswc_pkg::cat_t               cat;
    logic                         threat;

    assign voc  = 24'(sample.voc_milli);
    assign iaq  = 24'(sample.iaq_tenths);
    assign pm   = 24'(sample.pm25_tenths);
    assign hum  = 24'(sample.humidity_tenths);
    assign gas  = sample.gas_ohms;
    assign temp = sample.temp_tenths;

    assign vs       = aswc_pkg::BASE_W'(sample.voc_milli) << aswc_pkg::FRAC_BITS;
    assign diff     = aswc_pkg::DIFF_W'(vs) - aswc_pkg::DIFF_W'(baseline);
    assign diff_neg = diff[aswc_pkg::DIFF_W-1];
    assign diff_abs = diff_neg ? (~diff + 1'b1) : diff;
    assign adiff    = diff_abs[aswc_pkg::BASE_W-1:0];

    assign low     = gas < cfg.low_gas_limit;
    assign susp    = gas < cfg.suspicious_gas_limit;
    assign lpg_gas = aswc_pkg::win(gas, 24'd5595, 24'd5605);

    always_comb
    begin
        threat = 1'b1;
        priority if (aswc_pkg::win(voc, 24'd600, 24'd700) && aswc_pkg::win(iaq, 24'd700, 24'd800)
                     && aswc_pkg::win(pm, 24'd200, 24'd300))
            cat = aswc_pkg::CAT_LETHAL_OPIOID;
        else if (aswc_pkg::win(voc, 24'd550, 24'd650) && aswc_pkg::win(iaq, 24'd600, 24'd700)
                 && aswc_pkg::win(pm, 24'd220, 24'd320))
            cat = aswc_pkg::CAT_COCKTAIL;
        else if (aswc_pkg::win(voc, 24'd520, 24'd580) && aswc_pkg::win(iaq, 24'd540, 24'd620)
                 && aswc_pkg::win(pm, 24'd250, 24'd350) && aswc_pkg::win(hum, 24'd760, 24'd820))
            cat = aswc_pkg::CAT_NEUROTOXIN;
        else if (aswc_pkg::win(voc, 24'd530, 24'd580) && aswc_pkg::win(iaq, 24'd540, 24'd620)
                 && aswc_pkg::win(pm, 24'd250, 24'd350))
            cat = aswc_pkg::CAT_HEAVY_METAL;
        else if (aswc_pkg::win(voc, 24'd520, 24'd570) && aswc_pkg::win(iaq, 24'd530, 24'd610)
                 && aswc_pkg::win(hum, 24'd760, 24'd830))
            cat = aswc_pkg::CAT_ORGANOPHOSPHATE;
        else if (aswc_pkg::win(iaq, 24'd550, 24'd700) && aswc_pkg::win(voc, 24'd500, 24'd700)
                 && (pm <= 24'd20) && aswc_pkg::win(hum, 24'd750, 24'd850))
            cat = aswc_pkg::CAT_GASEOUS;
        else if (aswc_pkg::win(voc, 24'd580, 24'd680) && aswc_pkg::win(iaq, 24'd650, 24'd750)
                 && aswc_pkg::win(pm, 24'd200, 24'd300))
            cat = aswc_pkg::CAT_OPIOID;
        else if (aswc_pkg::win(voc, 24'd495, 24'd515) && aswc_pkg::win(iaq, 24'd495, 24'd555)
                 && aswc_pkg::win(pm, 24'd20, 24'd90) && aswc_pkg::win(hum, 24'd780, 24'd840)
                 && aswc_pkg::win_s(temp, 11'sd290, 11'sd320))
            cat = aswc_pkg::CAT_SCOPOLAMINE;
        else if (aswc_pkg::win(voc, 24'd500, 24'd550) && aswc_pkg::win(iaq, 24'd500, 24'd580)
                 && lpg_gas)
            cat = aswc_pkg::CAT_KNOCKOUT;
        else if (aswc_pkg::win(gas, 24'd5580, 24'd5620) && aswc_pkg::win(hum, 24'd700, 24'd900)
                 && aswc_pkg::win_s(temp, 11'sd280, 11'sd350)
                 && aswc_pkg::win(iaq, 24'd450, 24'd850))
            cat = aswc_pkg::CAT_STEALTH_CHEM;
        else if (((iaq > 24'd580) || (iaq < 24'd420)) && (adiff < aswc_pkg::ADIFF_QUIET))
            cat = aswc_pkg::CAT_IAQ_ANOMALY;
        else if (lpg_gas && (adiff >= aswc_pkg::ADIFF_SPIKE))
            cat = aswc_pkg::CAT_LPG_SPIKE;
        else if (lpg_gas)
        begin
            cat    = aswc_pkg::CAT_LPG_ONLY;
            threat = 1'b0;
        end
        // gas resistance fallbacks
        else if ((iaq <= 24'd650) && (voc <= 24'd1200) && low)
            cat = aswc_pkg::CAT_STEALTH_CONTAM;
        else if ((iaq <= 24'd550) && (voc <= 24'd600) && susp)
            cat = aswc_pkg::CAT_MASKED;
        else if ((iaq <= 24'd350) && (voc <= 24'd400) && (gas > cfg.clean_gas_limit))
        begin
            cat    = aswc_pkg::CAT_CLEAN;
            threat = low;
        end
        else
        begin
            cat    = aswc_pkg::CAT_UNKNOWN;
            threat = susp || low;
        end
    end

    always_comb
    begin
        result.category        = cat;
        result.is_threat       = threat;
        result.is_spike        = sample.spike_in;
        result.spike_negative  = 1'b0;
        result.spike_magnitude = 16'd0;
        if (cat == aswc_pkg::CAT_LPG_SPIKE)
        begin
            result.spike_negative  = diff_neg || (diff == '0);
            result.spike_magnitude = adiff[aswc_pkg::BASE_W-1 -: 16];
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for air_sample_window_classifier_core: predicts every
// result item from each accepted sample and compares field by field.
// Depends on aswc_pkg and the classifier RTL.
module tb;

    localparam int unsigned CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = aswc_pkg::REG_INTERVAL;
    logic [31:0] cfg_data = '0;

    logic               sample_valid = 1'b0;
    logic               sample_stall;
    logic [31:0]        time_ms = '0;
    logic [15:0]        voc_milli = '0;
    logic [12:0]        iaq_tenths = '0;
    logic [13:0]        pm25_tenths = '0;
    logic [9:0]         humidity_tenths = '0;
    logic signed [10:0] temp_tenths = '0;
    logic [23:0]        gas_ohms = '0;
    logic               spike_in = 1'b0;

    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [4:0]  category;
    logic        is_threat;
    logic        is_spike;
    logic        spike_negative;
    logic [15:0] spike_magnitude;

    // predictor state and register copies
    longint      model_baseline = longint'(aswc_pkg::BASE_RESET);
    logic [31:0] model_last_time = '0;
    logic [31:0] model_interval = aswc_pkg::INTERVAL_RESET;
    logic [23:0] model_low = aswc_pkg::LOW_GAS_RESET;
    logic [23:0] model_susp = aswc_pkg::SUSP_GAS_RESET;
    logic [23:0] model_clean = aswc_pkg::CLEAN_GAS_RESET;

    aswc_pkg::result_t expected_verdicts[$];
    aswc_pkg::result_t want_verdict;
    logic [31:0] sample_clock = '0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned results_checked = 0;
    int unsigned settings_used = 1;
    bit [16:0]   cats_seen = '0;

    air_sample_window_classifier_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .time_ms         (time_ms),
        .voc_milli       (voc_milli),
        .iaq_tenths      (iaq_tenths),
        .pm25_tenths     (pm25_tenths),
        .humidity_tenths (humidity_tenths),
        .temp_tenths     (temp_tenths),
        .gas_ohms        (gas_ohms),
        .spike_in        (spike_in),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .category        (category),
        .is_threat       (is_threat),
        .is_spike        (is_spike),
        .spike_negative  (spike_negative),
        .spike_magnitude (spike_magnitude)
    );

    always #5 clk = ~clk;

    function automatic bit in_range(input longint v, input longint lo, input longint hi);
        return (v >= lo) && (v <= hi);
    endfunction

    // EMA update on elapsed interval, then the window chain and gas fallbacks
    function automatic aswc_pkg::result_t judge_sample(input aswc_pkg::sample_t s);
        aswc_pkg::result_t r;
        logic [31:0]       elapsed;
        longint            voc, iaq, pm, hum, temp, gas, diff, adiff, dev, unit;
        bit                low, susp;
        aswc_pkg::cat_t    cat;
        elapsed = s.time_ms - model_last_time;
        voc = s.voc_milli;
        iaq = s.iaq_tenths;
        pm = s.pm25_tenths;
        hum = s.humidity_tenths;
        temp = $signed(s.temp_tenths);
        gas = s.gas_ohms;
        if (elapsed > model_interval)
        begin
            model_baseline = (4 * model_baseline + (voc << aswc_pkg::FRAC_BITS)) / 5;
            model_last_time = s.time_ms;
        end
        unit = longint'(1) << aswc_pkg::FRAC_BITS;
        diff = voc * unit - model_baseline;
        adiff = (diff < 0) ? -diff : diff;
        dev = (iaq > 500) ? iaq - 500 : 500 - iaq;
        r.is_threat = 1'b0;
        r.is_spike = s.spike_in;
        r.spike_negative = 1'b0;
        r.spike_magnitude = '0;

        if (in_range(voc, 600, 700) && in_range(iaq, 700, 800) && in_range(pm, 200, 300))
            cat = aswc_pkg::CAT_LETHAL_OPIOID;
        else if (in_range(voc, 550, 650) && in_range(iaq, 600, 700) && in_range(pm, 220, 320))
            cat = aswc_pkg::CAT_COCKTAIL;
        else if (in_range(voc, 520, 580) && in_range(iaq, 540, 620) && in_range(pm, 250, 350)
                 && in_range(hum, 760, 820))
            cat = aswc_pkg::CAT_NEUROTOXIN;
        else if (in_range(voc, 530, 580) && in_range(iaq, 540, 620) && in_range(pm, 250, 350))
            cat = aswc_pkg::CAT_HEAVY_METAL;
        else if (in_range(voc, 520, 570) && in_range(iaq, 530, 610) && in_range(hum, 760, 830))
            cat = aswc_pkg::CAT_ORGANOPHOSPHATE;
        else if (in_range(iaq, 550, 700) && in_range(voc, 500, 700) && pm <= 20
                 && in_range(hum, 750, 850))
            cat = aswc_pkg::CAT_GASEOUS;
        else if (in_range(voc, 580, 680) && in_range(iaq, 650, 750) && in_range(pm, 200, 300))
            cat = aswc_pkg::CAT_OPIOID;
        else if (in_range(voc, 495, 515) && in_range(iaq, 495, 555) && in_range(pm, 20, 90)
                 && in_range(hum, 780, 840) && in_range(temp, 290, 320))
            cat = aswc_pkg::CAT_SCOPOLAMINE;
        else if (in_range(voc, 500, 550) && in_range(iaq, 500, 580) && in_range(gas, 5595, 5605))
            cat = aswc_pkg::CAT_KNOCKOUT;
        else if (in_range(gas, 5580, 5620) && in_range(hum, 700, 900)
                 && in_range(temp, 280, 350) && in_range(iaq, 450, 850))
            cat = aswc_pkg::CAT_STEALTH_CHEM;
        else if (dev > 80 && adiff < 10 * unit)
            cat = aswc_pkg::CAT_IAQ_ANOMALY;
        else if (in_range(gas, 5595, 5605))
        begin
            if (adiff >= 5 * unit)
            begin
                cat = aswc_pkg::CAT_LPG_SPIKE;
                r.spike_negative = (diff <= 0);
                r.spike_magnitude = 16'(adiff >> aswc_pkg::FRAC_BITS);
            end
            else
                cat = aswc_pkg::CAT_LPG_ONLY;
        end
        else
            cat = aswc_pkg::CAT_UNKNOWN;

        if (cat <= aswc_pkg::CAT_LPG_SPIKE)
            r.is_threat = 1'b1;
        else if (cat == aswc_pkg::CAT_UNKNOWN)
        begin
            low = gas < model_low;
            susp = gas < model_susp;
            if (iaq <= 650 && voc <= 1200 && low)
            begin
                cat = aswc_pkg::CAT_STEALTH_CONTAM;
                r.is_threat = 1'b1;
            end
            else if (iaq <= 550 && voc <= 600 && susp)
            begin
                cat = aswc_pkg::CAT_MASKED;
                r.is_threat = 1'b1;
            end
            else if (iaq <= 350 && voc <= 400 && gas > model_clean)
                cat = aswc_pkg::CAT_CLEAN;
            else if (susp)
                r.is_threat = 1'b1;
            if (low)
                r.is_threat = 1'b1;
        end
        r.category = cat;
        return r;
    endfunction

    function automatic aswc_pkg::sample_t make_sample(input logic [31:0] t, input int voc,
                                                      input int iaq, input int pm,
                                                      input int hum, input int temp,
                                                      input int gas, input bit spike);
        aswc_pkg::sample_t s;
        s.time_ms = t;
        s.voc_milli = 16'(voc);
        s.iaq_tenths = 13'(iaq);
        s.pm25_tenths = 14'(pm);
        s.humidity_tenths = 10'(hum);
        s.temp_tenths = 11'(temp);
        s.gas_ohms = 24'(gas);
        s.spike_in = spike;
        return s;
    endfunction

    // mostly near the detection windows, some realistic, some full-width noise
    function automatic aswc_pkg::sample_t random_sample();
        aswc_pkg::sample_t s;
        int unsigned       pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            sample_clock += $urandom_range(0, 400000);
        else if (pick < 16)
            sample_clock = model_last_time + model_interval + $urandom_range(0, 1);
        else if (pick < 18)
            sample_clock += $urandom_range(0, 50);
        else
            sample_clock = $urandom;
        s.time_ms = sample_clock;

        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            s.voc_milli = 16'($urandom_range(480, 720));
            s.iaq_tenths = 13'($urandom_range(430, 870));
            s.pm25_tenths = 14'($urandom_range(0, 360));
            s.humidity_tenths = 10'($urandom_range(680, 900));
            s.temp_tenths = 11'($urandom_range(260, 360));
            if ($urandom_range(0, 3) == 0)
                s.voc_milli = 16'((model_baseline >> aswc_pkg::FRAC_BITS)
                                  + $urandom_range(0, 24) - 12);
        end
        else if (pick < 80)
        begin
            s.voc_milli = 16'($urandom_range(0, 1300));
            s.iaq_tenths = 13'($urandom_range(0, 900));
            s.pm25_tenths = 14'($urandom_range(0, 400));
            s.humidity_tenths = 10'($urandom_range(0, 1000));
            s.temp_tenths = 11'(int'($urandom_range(0, 1250)) - 400);
        end
        else
        begin
            s.voc_milli = 16'($urandom);
            s.iaq_tenths = 13'($urandom);
            s.pm25_tenths = 14'($urandom);
            s.humidity_tenths = 10'($urandom);
            s.temp_tenths = 11'($urandom);
        end

        pick = $urandom_range(0, 9);
        if (pick < 4)
            s.gas_ohms = 24'($urandom_range(5575, 5625));
        else if (pick == 4)
            s.gas_ohms = 24'(model_low + $urandom_range(0, 2) - 1);
        else if (pick == 5)
            s.gas_ohms = 24'(model_susp + $urandom_range(0, 2) - 1);
        else if (pick == 6)
            s.gas_ohms = 24'(model_clean + $urandom_range(0, 2) - 1);
        else if (pick < 9)
            s.gas_ohms = 24'($urandom_range(0, 60000));
        else
            s.gas_ohms = 24'($urandom);
        s.spike_in = 1'($urandom);
        return s;
    endfunction

    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic offer_sample(input aswc_pkg::sample_t s);
        int unsigned       gap;
        aswc_pkg::result_t r;
        gap = tx_idle_on ? idle_length() : 0;
        if (gap != 0)
        begin
            @(negedge clk);
            sample_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        sample_valid <= 1'b1;
        time_ms <= s.time_ms;
        voc_milli <= s.voc_milli;
        iaq_tenths <= s.iaq_tenths;
        pm25_tenths <= s.pm25_tenths;
        humidity_tenths <= s.humidity_tenths;
        temp_tenths <= s.temp_tenths;
        gas_ohms <= s.gas_ohms;
        spike_in <= s.spike_in;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        r = judge_sample(s);
        cats_seen[r.category] = 1'b1;
        expected_verdicts.push_back(r);
    endtask

    task automatic drain_results();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input aswc_pkg::reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        unique case (idx)
            aswc_pkg::REG_INTERVAL:  model_interval = value;
            aswc_pkg::REG_LOW_GAS:   model_low = value[23:0];
            aswc_pkg::REG_SUSP_GAS:  model_susp = value[23:0];
            aswc_pkg::REG_CLEAN_GAS: model_clean = value[23:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [31:0] interval, input logic [31:0] low,
                                 input logic [31:0] susp, input logic [31:0] clean);
        drain_results();
        write_reg(aswc_pkg::REG_INTERVAL, interval);
        write_reg(aswc_pkg::REG_LOW_GAS, low);
        write_reg(aswc_pkg::REG_SUSP_GAS, susp);
        write_reg(aswc_pkg::REG_CLEAN_GAS, clean);
        settings_used++;
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count)
            offer_sample(random_sample());
    endtask

    // one sample per category at reset settings, plus field extremes
    task automatic test_categories();
        offer_sample(make_sample(100, 650, 750, 250, 0, 0, 100000, 0));
        offer_sample(make_sample(200, 600, 650, 250, 0, 0, 100000, 1));
        offer_sample(make_sample(300, 560, 580, 300, 800, 0, 100000, 0));
        offer_sample(make_sample(400, 560, 580, 300, 500, 0, 100000, 0));
        offer_sample(make_sample(500, 550, 550, 0, 800, 0, 100000, 0));
        offer_sample(make_sample(600, 600, 650, 10, 800, 0, 100000, 0));
        offer_sample(make_sample(700, 590, 720, 250, 0, 0, 100000, 0));
        offer_sample(make_sample(800, 505, 520, 50, 800, 300, 100000, 0));
        offer_sample(make_sample(900, 520, 550, 0, 0, 0, 5600, 0));
        offer_sample(make_sample(1000, 0, 600, 0, 800, 300, 5610, 0));
        offer_sample(make_sample(1100, 500, 700, 0, 0, 0, 100000, 0));
        offer_sample(make_sample(1200, 600, 500, 0, 0, 0, 5600, 1));
        offer_sample(make_sample(1300, 0, 500, 0, 0, 0, 5600, 0));
        offer_sample(make_sample(1400, 502, 450, 0, 0, 0, 5600, 0));
        offer_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 0));
        offer_sample(make_sample(1500, 500, 500, 0, 0, 0, 20000, 0));
        offer_sample(make_sample(1600, 300, 300, 0, 0, 0, 50000, 0));
        offer_sample(make_sample(1700, 65535, 8191, 16383, 1023, 1023, 24'hFFFFFF, 1));
        offer_sample(make_sample(1800, 0, 1000, 0, 0, -1024, 20000, 0));
    endtask

    // baseline timer across the 32-bit wrap, on and just past the interval
    task automatic test_timer_wrap();
        offer_sample(make_sample(32'hFFFF_FFF0, 65535, 500, 0, 0, 0, 5600, 0));
        offer_sample(make_sample(32'd299984, 0, 500, 0, 0, 0, 5600, 0));
        offer_sample(make_sample(32'd299985, 0, 500, 0, 0, 0, 5600, 1));
        sample_clock = 32'd299985;
    endtask

    task automatic test_config_corners();
        apply_setting(32'd0, 32'd0, 32'd0, 32'd0);
        tx_idle_on = 1'b0;
        send_random(30);
        apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b0;
        send_random(30);
        // limits in the wrong order
        apply_setting(32'd1000, 32'd40000, 32'd20000, 32'd5000);
        rx_idle_on = 1'b1;
        send_random(30);
        apply_setting($urandom_range(0, 600000), $urandom_range(0, 60000),
                      $urandom_range(0, 60000), $urandom_range(0, 60000));
        send_random(30);
        apply_setting(aswc_pkg::INTERVAL_RESET, aswc_pkg::LOW_GAS_RESET,
                      aswc_pkg::SUSP_GAS_RESET, aswc_pkg::CLEAN_GAS_RESET);
    endtask

    task automatic test_random_traffic();
        for (int burst = 0; burst < 5; burst++)
        begin
            if (burst % 2 == 1)
                apply_setting($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 600000),
                              $urandom_range(0, 60000), $urandom_range(0, 60000),
                              $urandom_range(0, 1) ? $urandom : $urandom_range(0, 60000));
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            send_random(50);
        end
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && rx_idle_on && $urandom_range(0, 3) == 0)
                stall_left = idle_length();
            if (stall_left != 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("result item with none expected, category %0d", category);
                mismatch_count++;
            end
            else
            begin
                want_verdict = expected_verdicts.pop_front();
                results_checked++;
                if (category !== want_verdict.category)
                begin
                    $error("category: expected %0d, got %0d", want_verdict.category, category);
                    mismatch_count++;
                end
                if (is_threat !== want_verdict.is_threat)
                begin
                    $error("is_threat: expected %0b, got %0b", want_verdict.is_threat, is_threat);
                    mismatch_count++;
                end
                if (is_spike !== want_verdict.is_spike)
                begin
                    $error("is_spike: expected %0b, got %0b", want_verdict.is_spike, is_spike);
                    mismatch_count++;
                end
                if (spike_negative !== want_verdict.spike_negative)
                begin
                    $error("spike_negative: expected %0b, got %0b",
                           want_verdict.spike_negative, spike_negative);
                    mismatch_count++;
                end
                if (spike_magnitude !== want_verdict.spike_magnitude)
                begin
                    $error("spike_magnitude: expected %0d, got %0d",
                           want_verdict.spike_magnitude, spike_magnitude);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_verdicts.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_categories();
        test_timer_wrap();
        test_config_corners();
        test_random_traffic();
        drain_results();
        repeat (8) @(posedge clk);
        $display("Checked %0d result items over %0d register settings; %0d of 17 categories hit",
                 results_checked, settings_used, $countones(cats_seen));
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/aswc_pkg.sv
rtl/aswc_baseline.sv
rtl/aswc_classify.sv
rtl/air_sample_window_classifier_core.sv
verif/tb.sv
